// ===== rtl/gdad_pkg.sv =====
// Shared types, constants and calendar helpers for the Gregorian date adder.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package gdad_pkg;

  // Field widths of the item ports
  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int DAYS_W   = 16;
  localparam int STATUS_W = 2;

  // Default limits
  localparam int unsigned DEF_MAX_ADD_DAYS = 65535;
  localparam int unsigned DEF_MAX_YEAR     = 9999;
  localparam int          DEF_ALU_W        = 17;

  // Year position inside the 400-year cycle
  localparam int R400_W = 9;
  localparam logic [R400_W-1:0] CYCLE_400     = 9'd400;
  localparam logic [R400_W-1:0] LAST_IN_CYCLE = 9'd399;
  localparam logic [R400_W-1:0] CENTURY_1     = 9'd100;
  localparam logic [R400_W-1:0] CENTURY_2     = 9'd200;
  localparam logic [R400_W-1:0] CENTURY_3     = 9'd300;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_DATE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_CLAMPED  = 2'd2;

  // Months
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // Month lengths
  localparam logic [DAY_W-1:0] DAYS_LONG   = 5'd31;
  localparam logic [DAY_W-1:0] DAYS_SHORT  = 5'd30;
  localparam logic [DAY_W-1:0] DAYS_LEAP   = 5'd29;
  localparam logic [DAY_W-1:0] DAYS_COMMON = 5'd28;

  typedef struct packed {
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
    logic [DAYS_W-1:0]  days_to_add;
  } req_t;

  typedef struct packed {
    logic [DAY_W-1:0]    new_day;
    logic [MONTH_W-1:0]  new_month;
    logic [YEAR_W-1:0]   new_year;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_CHECK,
    S_ADD,
    S_MONTH,
    S_DONE
  } state_t;

  typedef enum logic {
    ALU_SUB,
    ALU_ADD
  } alu_op_t;

  typedef enum logic [1:0] {
    SEL_REDUCE,
    SEL_MONTH,
    SEL_SUM
  } opnd_sel_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic take;
    logic range_bad;
    logic alu_ge;
    logic alu_gt;
    logic mon_last;
    logic year_last;
    logic out_free;
  } flags_t;

  // Sequencer commands to the datapath
  typedef struct packed {
    logic      busy;
    opnd_sel_t sel;
    alu_op_t   op;
    logic      load;
    logic      red_step;
    logic      set_bad;
    logic      sum_load;
    logic      month_step;
    logic      clamp;
    logic      finish;
  } ctrl_t;

  // Leap year from the year's position in the 400-year cycle
  function automatic logic is_leap(input logic [R400_W-1:0] r400);
    is_leap = (r400[1:0] == 2'b00) && (r400 != CENTURY_1) &&
              (r400 != CENTURY_2) && (r400 != CENTURY_3);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    if (m == MONTH_FEB) begin
      month_len = leap ? DAYS_LEAP : DAYS_COMMON;
    end else if (m inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV}) begin
      month_len = DAYS_SHORT;
    end else begin
      month_len = DAYS_LONG;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gdad_alu.sv =====
// Shared add/subtract and compare unit of the date adder.
// Depends on gdad_pkg for the operation type.
`default_nettype none

module gdad_alu #(
  parameter int W = gdad_pkg::DEF_ALU_W
) (
  input  logic              [W-1:0] a,
  input  logic              [W-1:0] b,
  input  gdad_pkg::alu_op_t         op,
  output logic              [W-1:0] res,
  output logic                      ge,
  output logic                      gt
);
  import gdad_pkg::*;

  // Compare always, add or subtract on request
  always_comb begin
    ge  = (a >= b);
    gt  = (a > b);
    res = (op == ALU_ADD) ? (a + b) : (a - b);
  end

endmodule

`default_nettype wire

// ===== rtl/gdad_ctrl.sv =====
// Sequencer of the date adder: walks one item through reduce, check, add
// and month steps. Depends on gdad_pkg for state, flag and command types.
`default_nettype none

module gdad_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  gdad_pkg::flags_t flags,
  output gdad_pkg::ctrl_t  ctrl
);
  import gdad_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (flags.take) begin
          state_next = flags.range_bad ? S_DONE : S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (!flags.alu_ge) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = flags.alu_gt ? S_DONE : S_ADD;
      end
      S_ADD: begin
        state_next = S_MONTH;
      end
      S_MONTH: begin
        if (!flags.alu_gt || (flags.mon_last && flags.year_last)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (flags.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    ctrl = '0;
    ctrl.busy = (state != S_IDLE);
    ctrl.sel  = SEL_MONTH;
    ctrl.op   = ALU_SUB;
    case (state)
      S_IDLE: begin
        ctrl.load = flags.take;
      end
      S_REDUCE: begin
        ctrl.sel      = SEL_REDUCE;
        ctrl.red_step = flags.alu_ge;
      end
      S_CHECK: begin
        ctrl.set_bad = flags.alu_gt;
      end
      S_ADD: begin
        ctrl.sel      = SEL_SUM;
        ctrl.op       = ALU_ADD;
        ctrl.sum_load = 1'b1;
      end
      S_MONTH: begin
        ctrl.month_step = flags.alu_gt && !(flags.mon_last && flags.year_last);
        ctrl.clamp      = flags.alu_gt && flags.mon_last && flags.year_last;
      end
      S_DONE: begin
        ctrl.finish = flags.out_free;
      end
      default: begin
        ctrl.busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/gregorian_date_add_days.sv =====
// Gregorian date adder: takes a date and a day count and returns the date
// that many days later, one item at a time. A single subtractor does all the
// work: it first finds the year's place in the 400-year leap cycle, one
// subtraction of 400 a cycle, then checks the day against its month, adds the
// count, and takes off one whole month per cycle. A date with a field out
// of range skips these steps and is echoed. Status 1 marks an invalid date
// echoed unchanged, status 2 a result clamped to 31/12/MAX_YEAR. req_stall
// stays high while an item is in work; a finished item waits in the output
// register. Depends on gdad_pkg, gdad_alu and gdad_ctrl.
`default_nettype none

module gregorian_date_add_days #(
  parameter int unsigned MAX_ADD_DAYS = gdad_pkg::DEF_MAX_ADD_DAYS,
  parameter int unsigned MAX_YEAR     = gdad_pkg::DEF_MAX_YEAR
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  gdad_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output gdad_pkg::rsp_t rsp
);
  import gdad_pkg::*;

  localparam int TW = $clog2(MAX_ADD_DAYS + 32);
  localparam int YW = $clog2(MAX_YEAR + 2);
  localparam int RW = (YW > R400_W) ? YW : R400_W;
  localparam int AW = (TW > RW) ? TW : RW;

  flags_t flags;
  ctrl_t  ctrl;

  req_t                item;
  logic [TW-1:0]       day_acc;
  logic [TW-1:0]       n_sat;
  logic [MONTH_W-1:0]  mon;
  logic [YW-1:0]       yr;
  logic [RW-1:0]       r400;
  logic [STATUS_W-1:0] st;

  logic [TW-1:0]    n_in;
  logic             range_bad;
  logic [DAY_W-1:0] mlen;
  logic [AW-1:0]    alu_a;
  logic [AW-1:0]    alu_b;
  logic [AW-1:0]    alu_res;
  logic             alu_ge;
  logic             alu_gt;

  // Screen fields and saturate the count
  always_comb begin
    range_bad = (req.start_day == '0) || (req.start_month == '0) ||
                (req.start_month > MONTH_DEC) || (req.start_year == '0) ||
                (32'(req.start_year) > MAX_YEAR);
    n_in = (32'(req.days_to_add) > MAX_ADD_DAYS) ? TW'(MAX_ADD_DAYS)
                                                 : TW'(req.days_to_add);
  end

  assign mlen = month_len(mon, is_leap(r400[R400_W-1:0]));

  // Select operands for the shared unit
  always_comb begin
    case (ctrl.sel)
      SEL_REDUCE: begin
        alu_a = AW'(r400);
        alu_b = AW'(CYCLE_400);
      end
      SEL_SUM: begin
        alu_a = AW'(day_acc);
        alu_b = AW'(n_sat);
      end
      default: begin
        alu_a = AW'(day_acc);
        alu_b = AW'(mlen);
      end
    endcase
  end

  gdad_alu #(
    .W (AW)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .op  (ctrl.op),
    .res (alu_res),
    .ge  (alu_ge),
    .gt  (alu_gt)
  );

  always_comb begin
    flags.take      = req_valid && !ctrl.busy;
    flags.range_bad = range_bad;
    flags.alu_ge    = alu_ge;
    flags.alu_gt    = alu_gt;
    flags.mon_last  = (mon == MONTH_DEC);
    flags.year_last = (yr == YW'(MAX_YEAR));
    flags.out_free  = !rsp_valid || !rsp_stall;
  end

  gdad_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  assign req_stall = ctrl.busy;

  // Working registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      item    <= req;
      day_acc <= TW'(req.start_day);
      mon     <= req.start_month;
      yr      <= YW'(req.start_year);
      r400    <= RW'(req.start_year);
      n_sat   <= n_in;
      st      <= range_bad ? STATUS_BAD_DATE : STATUS_OK;
    end
    if (ctrl.red_step) begin
      r400 <= RW'(alu_res);
    end
    if (ctrl.set_bad) begin
      st <= STATUS_BAD_DATE;
    end
    if (ctrl.sum_load) begin
      day_acc <= TW'(alu_res);
    end
    // Take off one month, roll the year at December
    if (ctrl.month_step) begin
      day_acc <= TW'(alu_res);
      if (mon == MONTH_DEC) begin
        mon  <= MONTH_JAN;
        yr   <= yr + YW'(1);
        r400 <= (r400 == RW'(LAST_IN_CYCLE)) ? '0 : r400 + RW'(1);
      end else begin
        mon <= mon + MONTH_W'(1);
      end
    end
    if (ctrl.clamp) begin
      day_acc <= TW'(DAYS_LONG);
      mon     <= MONTH_DEC;
      yr      <= YW'(MAX_YEAR);
      st      <= STATUS_CLAMPED;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      if (st == STATUS_BAD_DATE) begin
        rsp.new_day   <= item.start_day;
        rsp.new_month <= item.start_month;
        rsp.new_year  <= item.start_year;
      end else begin
        rsp.new_day   <= DAY_W'(day_acc);
        rsp.new_month <= mon;
        rsp.new_year  <= YEAR_W'(yr);
      end
      rsp.status <= st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gdad_checker.sv =====
// Port-level checks for the Gregorian date adder, bound to its top level.
// Depends on gdad_pkg and gregorian_date_add_days.
`default_nettype none

module gdad_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input gdad_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input gdad_pkg::rsp_t rsp
);
  import gdad_pkg::*;

  // Block goes busy once it takes an item
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("block ready right after taking an item");

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed or dropped");

  // Only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == STATUS_OK || rsp.status == STATUS_BAD_DATE ||
                   rsp.status == STATUS_CLAMPED))
    else $error("undefined status code");

  // Clamped result is the last day of the year
  a_clamp_date: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == STATUS_CLAMPED |->
      rsp.new_day == DAYS_LONG && rsp.new_month == MONTH_DEC)
    else $error("clamped result is not 31 December");

  // A good result is a real day and month
  a_ok_date: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == STATUS_OK |->
      rsp.new_day != '0 && rsp.new_month != '0 && rsp.new_month <= MONTH_DEC)
    else $error("good result carries an impossible day or month");

endmodule

bind gregorian_date_add_days gdad_checker u_gdad_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire
